// ===== sv/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// shared types, constants and the character table of the base64 encoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64enc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GROUP_W = 24;
    localparam int unsigned IDX_W   = 6;

    localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3d;   // '='

    // group fill codes
    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_TWO   = 2'd2;

    // characters per group, before padding
    localparam logic [2:0] NCHAR_ONE_BYTE  = 3'd2;
    localparam logic [2:0] NCHAR_TWO_BYTES = 3'd3;
    localparam logic [2:0] NCHAR_FULL      = 3'd4;

    localparam logic [1:0] LAST_SLOT = 2'd3;

    // one complete or zero-filled group handed from front to back
    typedef struct packed {
        logic [GROUP_W-1:0] bits;       // first byte in the top bits
        logic [2:0]         num_chars;  // alphabet characters, rest is padding
        logic               fin;        // group closes the message
    } b64enc_grp_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } b64enc_qstat_t;

    // standard alphabet lookup
    function automatic logic [BYTE_W-1:0] b64_char(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] ext;
        ext = {2'b00, idx};
        if (idx < 6'd26)
            return 8'(8'h41 + ext);
        else if (idx < 6'd52)
            return 8'(8'h61 + ext - 8'd26);
        else if (idx < 6'd62)
            return 8'(8'h30 + ext - 8'd52);
        else if (idx == 6'd62)
            return 8'h2b;
        else
            return 8'h2f;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// collects input bytes into groups of three and hands closed groups on
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      final_byte,
    output logic                           push,
    output b64enc_pkg::b64enc_grp_t        grp
);

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  fill_reg, fill_next;
    logic [1:0]  fill_eff;
    logic [7:0]  g0, g1, g2;
    logic        emit;

    always_comb
    begin
        // a fill of three never occurs, treat it as two
        fill_eff = (fill_reg == 2'd3) ? b64enc_pkg::FILL_TWO : fill_reg;

        g0 = (fill_eff == b64enc_pkg::FILL_EMPTY) ? data_byte : pend_reg[15:8];
        g1 = (fill_eff == b64enc_pkg::FILL_ONE) ? data_byte :
             (fill_eff == b64enc_pkg::FILL_TWO) ? pend_reg[7:0] : 8'h00;
        g2 = (fill_eff == b64enc_pkg::FILL_TWO) ? data_byte : 8'h00;

        emit = (fill_eff == b64enc_pkg::FILL_TWO) || final_byte;
        push = accept && emit;

        grp.bits = {g0, g1, g2};
        grp.fin  = final_byte;
        case (fill_eff)
            b64enc_pkg::FILL_EMPTY: grp.num_chars = b64enc_pkg::NCHAR_ONE_BYTE;
            b64enc_pkg::FILL_ONE:   grp.num_chars = b64enc_pkg::NCHAR_TWO_BYTES;
            default:                grp.num_chars = b64enc_pkg::NCHAR_FULL;
        endcase

        pend_next = pend_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (emit)
            begin
                pend_next = 16'h0000;
                fill_next = b64enc_pkg::FILL_EMPTY;
            end
            else
            begin
                if (fill_eff == b64enc_pkg::FILL_EMPTY)
                    pend_next = {data_byte, 8'h00};
                else
                    pend_next = {pend_reg[15:8], data_byte};
                fill_next = 2'(fill_eff + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 16'h0000;
            fill_reg <= b64enc_pkg::FILL_EMPTY;
        end
        else
        begin
            pend_reg <= pend_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64enc_fifo.sv =====
// ----------------------------------------------------------------------------
// b64enc_fifo
// short queue of closed groups between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire b64enc_pkg::b64enc_grp_t   din,
    input  wire logic                      pop,
    output b64enc_pkg::b64enc_grp_t        dout,
    output b64enc_pkg::b64enc_qstat_t      stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64enc_pkg::b64enc_grp_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    always_comb
    begin
        stat.full  = (cnt_reg == FULL_CNT);
        stat.empty = (cnt_reg == '0);
        do_push = push && !stat.full;
        do_pop  = pop && !stat.empty;
        dout    = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PW'(rd_ptr_reg + 1'b1);

        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = CW'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = CW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// turns queued groups into characters for an output register, one per cycle unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire b64enc_pkg::b64enc_grp_t   q_grp,
    input  wire b64enc_pkg::b64enc_qstat_t q_stat,
    output logic                           q_pop,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     out_char,
    output logic                           run_last,
    output logic                           message_end
);

    b64enc_pkg::b64enc_grp_t cur_reg, cur_next;
    logic       active_reg, active_next;
    logic [1:0] slot_reg, slot_next;
    logic       ov_reg, ov_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       end_reg, end_next;
    logic       load_ok;
    logic [5:0] idx;

    always_comb
    begin
        load_ok = !ov_reg || out_ready;

        case (slot_reg)
            2'd0:    idx = cur_reg.bits[23:18];
            2'd1:    idx = cur_reg.bits[17:12];
            2'd2:    idx = cur_reg.bits[11:6];
            default: idx = cur_reg.bits[5:0];
        endcase

        cur_next    = cur_reg;
        active_next = active_reg;
        slot_next   = slot_reg;
        ov_next     = ov_reg && !out_ready;
        char_next   = char_reg;
        last_next   = last_reg;
        end_next    = end_reg;
        q_pop       = 1'b0;

        if (load_ok && active_reg)
        begin
            ov_next   = 1'b1;
            char_next = ({1'b0, slot_reg} < cur_reg.num_chars) ?
                        b64enc_pkg::b64_char(idx) : b64enc_pkg::PAD_CHAR;
            last_next = (slot_reg == b64enc_pkg::LAST_SLOT);
            end_next  = (slot_reg == b64enc_pkg::LAST_SLOT) && cur_reg.fin;
            slot_next = 2'(slot_reg + 2'd1);
            if (slot_reg == b64enc_pkg::LAST_SLOT)
            begin
                // chain straight into the next queued group
                q_pop       = !q_stat.empty;
                active_next = !q_stat.empty;
                cur_next    = q_grp;
                slot_next   = 2'd0;
            end
        end
        else if (!active_reg && !q_stat.empty)
        begin
            q_pop       = 1'b1;
            active_next = 1'b1;
            cur_next    = q_grp;
            slot_next   = 2'd0;
        end

        out_valid   = ov_reg;
        out_char    = char_reg;
        run_last    = last_reg;
        message_end = end_reg;
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        char_reg <= char_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            slot_reg   <= 2'd0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            slot_reg   <= slot_next;
            ov_reg     <= ov_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/base64_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// usage
//   slave channel: one raw byte per item in s_axis_tdata, s_axis_tlast marks
//   the final byte of a message. master channel: one ascii character per item
//   in m_axis_tdata, m_axis_tlast on the last character caused by one input
//   byte (always the fourth of a group), m_axis_tuser on the last character
//   of the whole message.
//   a byte that closes a group (third byte, or a final byte) yields four
//   characters; other bytes are only held and yield nothing.
//   the first character of a group leaves the output register after the
//   group passes the queue and the back end's group register; the other
//   three follow one per cycle while m_axis_tready is high. the back end
//   emits one character per cycle while it holds a group and the output is
//   taken; the front takes a byte every cycle while the group queue has room.
//   reset: held bytes are dropped, the queue and output register empty.
//   stall: while m_axis_tready is low the output register holds its item,
//   the group queue fills and then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2   // closed groups held between stages
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input bytes
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // data_byte
    input  wire logic       s_axis_tlast,   // final_byte
    // encoded characters
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_char
    output logic            m_axis_tlast,   // run_last
    output logic            m_axis_tuser    // message_end
);

    b64enc_pkg::b64enc_grp_t   front_grp;
    b64enc_pkg::b64enc_grp_t   queue_grp;
    b64enc_pkg::b64enc_qstat_t queue_stat;
    logic                      front_push;
    logic                      back_pop;
    logic                      in_accept;

    // a byte is taken only with room for the group it might close
    assign s_axis_tready = !queue_stat.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // front: grouping of input bytes
    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .data_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .push       (front_push),
        .grp        (front_grp)
    );

    // queue of closed groups
    b64enc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_grp),
        .pop   (back_pop),
        .dout  (queue_grp),
        .stat  (queue_stat)
    );

    // back: character serialiser and output register
    b64enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_grp       (queue_grp),
        .q_stat      (queue_stat),
        .q_pop       (back_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_char    (m_axis_tdata),
        .run_last    (m_axis_tlast),
        .message_end (m_axis_tuser)
    );

endmodule

`default_nettype wire
